// ===== rtl/bfid_pkg.sv =====
// bidirectional flow id table: shared types, constants and state encoding
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package bfid_pkg;

    // fixed field widths
    localparam int FLOW_ID_W   = 7;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int ENTRIES_DEF = 64;

    // one input item
    typedef struct packed {
        logic              is_ipv4;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } t_in;

    // one result item
    typedef struct packed {
        logic [FLOW_ID_W-1:0] flow_id;
        logic                 is_new;
        logic                 table_full;
    } t_out;

    // stored flow key, 96 bits
    typedef struct packed {
        logic [ADDR_W-1:0] a_src;
        logic [ADDR_W-1:0] a_dst;
        logic [PORT_W-1:0] p_src;
        logic [PORT_W-1:0] p_dst;
    } t_key;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_end;
    } t_stat;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/bfid_ctrl.sv =====
// bidirectional flow id table: sequencing state machine
// depends on bfid_pkg; drives the datapath through t_cmd, watches t_stat
`timescale 1ns / 1ps
`default_nettype none

module bfid_ctrl import bfid_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_busy = 1'b1;
                if (i_stat.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bfid_datapath.sv =====
// bidirectional flow id table: key memory, scan pipeline, hit tracking, result register
// depends on bfid_pkg; commanded by bfid_ctrl
`timescale 1ns / 1ps
`default_nettype none

module bfid_datapath import bfid_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_in   i_item,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_valid,
    output t_out  o_result
);

    localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDW = $clog2(ENTRIES + 1);

    // key memory, entries below r_count are valid
    t_key            r_mem [ENTRIES];
    t_key            r_rd_data;

    t_key            r_key;
    logic            r_ipv4;
    logic [IDW-1:0]  r_count;
    logic [IDW-1:0]  r_rd_idx;
    logic            r_cmp_vld;
    logic [AW-1:0]   r_cmp_idx;
    logic            r_fwd_hit;
    logic [AW-1:0]   r_fwd_pos;
    logic            r_bwd_hit;
    logic [AW-1:0]   r_bwd_pos;
    logic            r_valid;
    t_out            r_result;

    t_key            bwd_key;
    logic            rd_more;
    logic            fwd_eq;
    logic            bwd_eq;
    logic            has_room;
    logic            ins;
    t_out            res;

    // swapped key of the held packet
    assign bwd_key = '{a_src: r_key.a_dst, a_dst: r_key.a_src,
                       p_src: r_key.p_dst, p_dst: r_key.p_src};

    assign rd_more  = r_ipv4 && !r_fwd_hit && (r_rd_idx < r_count);
    assign fwd_eq   = (r_rd_data == r_key);
    assign bwd_eq   = (r_rd_data == bwd_key);
    assign has_room = (r_count < IDW'(ENTRIES));
    assign ins      = r_ipv4 && !r_fwd_hit && !r_bwd_hit && has_room;

    assign o_stat.scan_end = !r_ipv4 || r_fwd_hit || (!rd_more && !r_cmp_vld);

    // result of the finished search
    always_comb begin
        res = '0;
        if (r_ipv4) begin
            if (r_fwd_hit) begin
                res.flow_id = FLOW_ID_W'(IDW'(r_fwd_pos) + IDW'(1));
            end else if (r_bwd_hit) begin
                res.flow_id = FLOW_ID_W'(IDW'(r_bwd_pos) + IDW'(1));
            end else if (has_room) begin
                res.flow_id = FLOW_ID_W'(r_count + IDW'(1));
                res.is_new  = 1'b1;
            end else begin
                res.table_full = 1'b1;
            end
        end
    end

    // memory read and append
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && rd_more) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
        if (i_cmd.finish && ins) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end
    end

    // packet key and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= '{a_src: i_item.src_addr, a_dst: i_item.dst_addr,
                       p_src: i_item.src_port, p_dst: i_item.dst_port};
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
        if (i_cmd.finish) begin
            r_result <= res;
        end
    end

    // scan control, hit tracking and flow count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv4    <= 1'b0;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_fwd_pos <= '0;
            r_bwd_hit <= 1'b0;
            r_bwd_pos <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_ipv4    <= i_item.is_ipv4;
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_fwd_hit <= 1'b0;
                r_bwd_hit <= 1'b0;
            end
            if (i_cmd.scan) begin
                // issue the next read
                r_cmp_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + IDW'(1);
                end
                // compare the entry read last cycle, first match wins
                if (r_cmp_vld && !r_fwd_hit) begin
                    if (fwd_eq) begin
                        r_fwd_hit <= 1'b1;
                        r_fwd_pos <= r_cmp_idx;
                    end
                    if (bwd_eq && !r_bwd_hit) begin
                        r_bwd_hit <= 1'b1;
                        r_bwd_pos <= r_cmp_idx;
                    end
                end
            end
            if (i_cmd.finish && ins) begin
                r_count <= r_count + IDW'(1);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/bidirectional_flow_id_table.sv =====
// bidirectional flow id table: top level, controller plus datapath
// depends on bfid_pkg, bfid_ctrl and bfid_datapath
//
// usage:
// - an item transfer happens at a rising edge with start high and busy low;
//   i_item carries the IPv4 flag, addresses and ports of one packet
// - each item gives exactly one result on o_result, shown for one cycle with
//   o_valid high; the receiver cannot stall it and must take it then
// - the stored flow keys are scanned one entry per cycle through a single
//   read port of the key memory with a registered read, forward and swapped
//   keys compared against each entry in the same cycle
// - with n flows stored, o_valid follows a scan of at most n entries, ended
//   early by a forward hit; a non-IPv4 packet skips the scan
// - busy is high from the transfer until the cycle o_valid shows; start may
//   be raised again in the cycle o_valid is high
// - a new flow is appended at the next free entry and gets id count + 1;
//   with all ENTRIES in use an unknown flow reports table_full and id 0
// - reset empties the table at once (flow count cleared, no sweep) and
//   drops any search in progress
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_flow_id_table import bfid_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   start,
    output logic  busy,
    input  t_in   i_item,
    output logic  o_valid,
    output t_out  o_result
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    bfid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // table and search
    bfid_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result is shown only once the controller is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // a full table never also reports a new entry and carries id zero
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.table_full) |->
            (!o_result.is_new && (o_result.flow_id == '0)))
        else $error("table full result is inconsistent");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for bidirectional_flow_id_table: a directed packet table, then random traffic
// depends on bfid_pkg and the rtl top level; expected ids come from a local copy of the table
`timescale 1ns / 1ps

module testbench;
    import bfid_pkg::*;

    localparam int TABLE_DEPTH    = ENTRIES_DEF;
    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;

    // how a row of the directed table is checked
    typedef enum bit {
        PREDICTED,
        FIXED
    } t_check;

    typedef struct {
        t_in    pkt;
        t_check check;
        t_out   want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    // local copy of the flow table
    t_key flow_store [TABLE_DEPTH];
    bit   flow_live  [TABLE_DEPTH];
    int   flows_held = 0;

    t_out pending_ids [$];
    t_in  seen_flows  [$];
    t_row plan        [$];

    int errors      = 0;
    int idle_cycles = 0;
    int n_new = 0, n_hit = 0, n_full = 0, n_other = 0, n_ipv4 = 0;
    bit idle_mode   = 1'b1;

    bidirectional_flow_id_table #(
        .ENTRIES (TABLE_DEPTH)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // position + 1 of the first live entry holding the key, or 0
    function automatic int find_flow(input t_key k);
        for (int i = 0; i < flows_held; i++) begin
            if (flow_live[i] && flow_store[i] == k) return i + 1;
        end
        return 0;
    endfunction

    // id lookup with forward key first, then swapped key, else append
    function automatic t_out classify_packet(input t_in pkt);
        t_key fwd;
        t_key rev;
        t_out res;
        int   hit;
        res = '0;
        if (pkt.is_ipv4) begin
            fwd = {pkt.src_addr, pkt.dst_addr, pkt.src_port, pkt.dst_port};
            rev = {pkt.dst_addr, pkt.src_addr, pkt.dst_port, pkt.src_port};
            hit = find_flow(fwd);
            if (hit == 0) hit = find_flow(rev);
            if (hit != 0) begin
                res.flow_id = FLOW_ID_W'(hit);
            end else if (flows_held < TABLE_DEPTH) begin
                flow_store[flows_held] = fwd;
                flow_live[flows_held]  = 1'b1;
                flows_held++;
                res.flow_id = FLOW_ID_W'(flows_held);
                res.is_new  = 1'b1;
            end else begin
                res.table_full = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic add_row(input bit v4, input logic [31:0] sa, da,
                           input logic [15:0] sp, dp, input t_check check,
                           input int id, input bit nw, full);
        t_row row;
        row.pkt   = '{is_ipv4: v4, src_addr: sa, dst_addr: da, src_port: sp, dst_port: dp};
        row.check = check;
        row.want  = '{flow_id: FLOW_ID_W'(id), is_new: nw, table_full: full};
        plan.push_back(row);
    endtask

    function automatic t_in random_flow();
        t_in p;
        p.is_ipv4  = 1'b1;
        p.src_addr = $urandom;
        p.dst_addr = $urandom;
        p.src_port = 16'($urandom_range(0, 65535));
        p.dst_port = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            // no tcp/udp header, ports read as zero
            0: begin
                p.src_port = '0;
                p.dst_port = '0;
            end
            // same endpoint both ways, forward and swapped keys are equal
            1: begin
                p.dst_addr = p.src_addr;
                p.dst_port = p.src_port;
            end
            default: ;
        endcase
        return p;
    endfunction

    // one packet transfer, starting and ending at a falling edge
    task automatic drive_packet(input t_in pkt, input t_check check, input t_out want);
        int   gap;
        t_out res;
        gap = idle_mode ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= pkt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = classify_packet(pkt);
        pending_ids.push_back(check == FIXED ? want : res);
        if (!pkt.is_ipv4) begin
            n_other++;
        end else begin
            n_ipv4++;
            if (res.is_new) begin
                n_new++;
                seen_flows.push_back(pkt);
            end else if (res.table_full) begin
                n_full++;
            end else begin
                n_hit++;
            end
        end
        @(negedge i_clk);
    endtask

    // result check and transfer activity for the watchdog
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (pending_ids.size() == 0) begin
                    note_mismatch("result with none pending, flow_id", o_result.flow_id, 0);
                end else begin
                    want = pending_ids.pop_front();
                    if (o_result.flow_id !== want.flow_id)
                        note_mismatch("flow_id", o_result.flow_id, want.flow_id);
                    if (o_result.is_new !== want.is_new)
                        note_mismatch("is_new", o_result.is_new, want.is_new);
                    if (o_result.table_full !== want.table_full)
                        note_mismatch("table_full", o_result.table_full, want.table_full);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_in  pkt;
        t_key key;
        t_out none;
        int   pick;
        int   lap;
        none = '0;
        lap  = 0;

        // directed packets: v4, src, dst, sport, dport, check, id, new, full
        add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, FIXED, 0, 0, 0);
        add_row(1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, FIXED, 1, 1, 0);
        add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, FIXED, 2, 1, 0);
        add_row(1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, FIXED, 1, 0, 0);
        add_row(0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, FIXED, 0, 0, 0);
        add_row(1, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80,   FIXED, 3, 1, 0);
        add_row(1, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,   16'd1234, FIXED, 3, 0, 0);
        add_row(1, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80,   FIXED, 3, 0, 0);
        add_row(0, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80,   FIXED, 0, 0, 0);
        add_row(1, 32'h7F00_0001, 32'h7F00_0001, 16'd53,   16'd53,   FIXED, 4, 1, 0);
        add_row(1, 32'h7F00_0001, 32'h7F00_0001, 16'd53,   16'd53,   FIXED, 4, 0, 0);
        add_row(1, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000, FIXED, 5, 1, 0);
        add_row(1, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, FIXED, 5, 0, 0);
        add_row(1, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, PREDICTED, 0, 0, 0);
        add_row(1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, PREDICTED, 0, 0, 0);
        // near misses of a stored flow: one port off, addresses swapped alone, ports swapped alone
        add_row(1, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd81,   PREDICTED, 0, 0, 0);
        add_row(1, 32'hC0A8_0001, 32'h0A00_0001, 16'd1234, 16'd80,   PREDICTED, 0, 0, 0);
        add_row(1, 32'h0A00_0001, 32'hC0A8_0001, 16'd80,   16'd1234, PREDICTED, 0, 0, 0);
        add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, FIXED, 2, 0, 0);

        // synchronous reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) drive_packet(plan[r].pkt, plan[r].check, plan[r].want);

        // random traffic: mostly known flows both ways, new flows fill the table
        while ((n_ipv4 + n_other) < ITEM_TARGET) begin
            if (lap % 40 == 0) idle_mode = ($urandom_range(0, 3) != 0);
            lap++;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                pkt = random_flow();
                pkt.is_ipv4 = 1'b0;
            end else if (pick < 22 || seen_flows.size() == 0) begin
                pkt = random_flow();
            end else begin
                pkt = seen_flows[$urandom_range(0, seen_flows.size() - 1)];
                if (pick < 30) begin
                    // single bit flip of a known key
                    key = {pkt.src_addr, pkt.dst_addr, pkt.src_port, pkt.dst_port};
                    key = key ^ (96'd1 << $urandom_range(0, 95));
                    {pkt.src_addr, pkt.dst_addr, pkt.src_port, pkt.dst_port} = key;
                end else if (pick < 65) begin
                    // reverse direction of a known flow
                    key = {pkt.dst_addr, pkt.src_addr, pkt.dst_port, pkt.src_port};
                    {pkt.src_addr, pkt.dst_addr, pkt.src_port, pkt.dst_port} = key;
                end
            end
            drive_packet(pkt, PREDICTED, none);
        end
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_ids.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ipv4 packets and %0d non-ipv4 packets", n_ipv4, n_other);
        $display("new flows %0d, repeat hits %0d, table full %0d, mismatches %0d",
                 n_new, n_hit, n_full, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
